// ===== src/base62_encode_128_macros.svh =====
// Assertion macros shared by the checker files of the base-62 encoder.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef BASE62_ENCODE_128_MACROS_SVH
`define BASE62_ENCODE_128_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define B62_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("base62 encoder: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define B62_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("base62 encoder: next-cycle check failed");

`endif

// ===== src/b62_pkg.sv =====
// Shared types, constants and the digit-to-ASCII function of the base-62 encoder.
// Depends on nothing; every other file but the macros header refers to it by scoped names.
package b62_pkg;

  localparam int unsigned RADIX      = 62;
  localparam int unsigned NUM_DIGITS = 22;
  localparam int unsigned VALUE_W    = 128;
  localparam int unsigned HALF_W     = 64;
  localparam int unsigned CHUNK_W    = 16;
  localparam int unsigned NUM_CHUNKS = VALUE_W / CHUNK_W;
  localparam int unsigned CHUNK_CNT_W = $clog2(NUM_CHUNKS);
  localparam int unsigned REM_W      = 6;
  localparam int unsigned PART_W     = CHUNK_W + REM_W;
  localparam int unsigned POS_W      = 5;
  localparam int unsigned CHAR_W     = 7;

  // Reciprocal of the radix, exact for every partial dividend below 2^PART_W.
  localparam int unsigned RECIP_SHIFT = PART_W + REM_W;
  localparam longint unsigned RECIP_VAL =
    ((64'd1 << RECIP_SHIFT) + RADIX - 1) / RADIX;
  localparam int unsigned RECIP_W = 23;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_VAL[RECIP_W-1:0];
  localparam int unsigned PROD_W = PART_W + RECIP_W;

  localparam logic [POS_W-1:0] FIRST_POS = '0;
  localparam logic [POS_W-1:0] LAST_POS  = POS_W'(NUM_DIGITS - 1);

  localparam logic [CHUNK_CNT_W-1:0] LAST_CHUNK = CHUNK_CNT_W'(NUM_CHUNKS - 1);

  localparam logic [CHAR_W-1:0] ASCII_ZERO    = 7'd48;
  localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 7'd65;
  localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 7'd97;
  localparam logic [REM_W-1:0]  DIGIT_TEN     = 6'd10;
  localparam logic [REM_W-1:0]  DIGIT_UPPER_END = 6'd36;
  localparam logic [REM_W-1:0]  DIGIT_LOWER_END = 6'd62;

  typedef struct packed {
    logic [CHUNK_W-1:0] quotient;
    logic [REM_W-1:0]   remainder;
  } div_res_t;

  // Alphabet 0-9, A-Z, a-z; codes past the alphabet map to '0'.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [REM_W-1:0] d);
    logic [CHAR_W-1:0] code;
    if (d < DIGIT_TEN) begin
      code = ASCII_ZERO + CHAR_W'(d);
    end else if (d < DIGIT_UPPER_END) begin
      code = ASCII_UPPER_A + CHAR_W'(d - DIGIT_TEN);
    end else if (d < DIGIT_LOWER_END) begin
      code = ASCII_LOWER_A + CHAR_W'(d - DIGIT_UPPER_END);
    end else begin
      code = ASCII_ZERO;
    end
    return code;
  endfunction

endpackage

// ===== src/b62_in_if.sv =====
// Input channel of the base-62 encoder: valid/ready with the 128-bit value.
// Depends on b62_pkg for the half width.
interface b62_in_if;
  logic                        valid;
  logic                        ready;
  logic [b62_pkg::HALF_W-1:0]  value_high;
  logic [b62_pkg::HALF_W-1:0]  value_low;

  modport source (output valid, output value_high, output value_low, input ready);
  modport sink   (input valid, input value_high, input value_low, output ready);
endinterface

// ===== src/b62_out_if.sv =====
// Output channel of the base-62 encoder: valid/ready with one character.
// Depends on b62_pkg for field widths.
interface b62_out_if;
  logic                        valid;
  logic                        ready;
  logic [b62_pkg::CHAR_W-1:0]  char_code;
  logic [b62_pkg::POS_W-1:0]   digit_position;
  logic                        last_digit;

  modport source (output valid, output char_code, output digit_position,
                  output last_digit, input ready);
  modport sink   (input valid, input char_code, input digit_position,
                  input last_digit, output ready);
endinterface

// ===== src/b62_chunk_div.sv =====
// Shared divider: one 16-bit chunk of long division by 62 per use.
// Depends on b62_pkg for widths, the reciprocal and the result struct.
module b62_chunk_div (
  input  logic [b62_pkg::REM_W-1:0]   rem,
  input  logic [b62_pkg::CHUNK_W-1:0] chunk,
  output b62_pkg::div_res_t           res
);

  logic [b62_pkg::PART_W-1:0] part;
  logic [b62_pkg::PROD_W-1:0] prod;
  logic [b62_pkg::CHUNK_W-1:0] quot;
  logic [b62_pkg::PART_W-1:0] quot_x62;
  logic [b62_pkg::PART_W-1:0] diff;

  // The incoming remainder is below 62, so the quotient fits in one chunk.
  assign part = {rem, chunk};
  assign prod = {{b62_pkg::RECIP_W{1'b0}}, part} *
                {{b62_pkg::PART_W{1'b0}}, b62_pkg::RECIP};
  assign quot = prod[b62_pkg::RECIP_SHIFT +: b62_pkg::CHUNK_W];

  // q * 62 as q * 64 - q * 2.
  assign quot_x62 = {quot, 6'b0} - {{(b62_pkg::REM_W - 1){1'b0}}, quot, 1'b0};
  assign diff     = part - quot_x62;

  assign res.quotient  = quot;
  assign res.remainder = diff[b62_pkg::REM_W-1:0];

endmodule

// ===== src/b62_digit_store.sv =====
// Generic RAM with one write port and one registered read port.
// Depends on b62_pkg for the default width and depth of the digit store.
module b62_digit_store #(
  parameter int unsigned WIDTH = b62_pkg::REM_W,
  parameter int unsigned DEPTH = b62_pkg::NUM_DIGITS,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] digits [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      digits[wr_addr] <= wr_data;
    end
    rd_data <= digits[rd_addr];
  end

endmodule

// ===== src/base62_encode_128.sv =====
// Top level of the 128-bit base-62 encoder: sequencer, working value, output register.
// Depends on b62_pkg, b62_in_if, b62_out_if, b62_chunk_div and b62_digit_store.
//
//   channel    direction  payload                                    per item
//   value_ch   in         value_high[63:0], value_low[63:0]          1 transaction
//   char_ch    out        char_code[6:0], digit_position[4:0], last  22 transactions
//
// One divider step handles a 16-bit chunk per cycle, step after step for each chunk of
// every digit and all 22 digits in turn; ST_FETCH then reads the first digit from the
// store. A stall on char_ch holds the sequencer where it is. value_ch is ready only
// while idle. The final character may still wait in the output register when the
// next value is accepted. Reset is synchronous and needs no clearing pass.
module base62_encode_128 (
  input  logic    clk,
  input  logic    rst,
  b62_in_if.sink  value_ch,
  b62_out_if.source char_ch
);

  typedef enum logic [1:0] {ST_IDLE, ST_DIVIDE, ST_FETCH, ST_EMIT} state_t;

  state_t                              state;
  logic [b62_pkg::VALUE_W-1:0]         working_value;
  logic [b62_pkg::REM_W-1:0]           rem;
  logic [b62_pkg::CHUNK_CNT_W-1:0]     chunk_cnt;
  logic [b62_pkg::POS_W-1:0]           wr_pos;
  logic [b62_pkg::POS_W-1:0]           digit_counter;
  logic                                out_valid;
  logic [b62_pkg::CHAR_W-1:0]          out_char;
  logic [b62_pkg::POS_W-1:0]           out_pos;
  logic                                out_last;

  b62_pkg::div_res_t                   div_res;
  logic                                store_wr;
  logic [b62_pkg::POS_W-1:0]           rd_pos;
  logic [b62_pkg::REM_W-1:0]           store_rd_data;
  logic                                out_load;

  b62_chunk_div u_div (
    .rem   (rem),
    .chunk (working_value[b62_pkg::VALUE_W-1 -: b62_pkg::CHUNK_W]),
    .res   (div_res)
  );

  assign store_wr = (state == ST_DIVIDE) && (chunk_cnt == b62_pkg::LAST_CHUNK);

  // The read is registered, so the address runs one character ahead of each load.
  assign rd_pos = (out_load && (digit_counter != b62_pkg::LAST_POS)) ?
                  digit_counter + 1'b1 : digit_counter;

  b62_digit_store #(
    .WIDTH (b62_pkg::REM_W),
    .DEPTH (b62_pkg::NUM_DIGITS)
  ) u_store (
    .clk     (clk),
    .wr_en   (store_wr),
    .wr_addr (wr_pos),
    .wr_data (div_res.remainder),
    .rd_addr (rd_pos),
    .rd_data (store_rd_data)
  );

  assign out_load = (state == ST_EMIT) && (!out_valid || char_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      working_value <= '0;
      rem           <= '0;
      chunk_cnt     <= '0;
      wr_pos        <= b62_pkg::LAST_POS;
      digit_counter <= b62_pkg::FIRST_POS;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && char_ch.ready && !out_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (value_ch.valid) begin
            working_value <= {value_ch.value_high, value_ch.value_low};
            rem           <= '0;
            chunk_cnt     <= '0;
            wr_pos        <= b62_pkg::LAST_POS;
            state         <= ST_DIVIDE;
          end
        end
        ST_DIVIDE: begin
          // The quotient chunk shifts in at the bottom, so after eight steps the
          // register holds the full quotient in order again.
          working_value <= {working_value[b62_pkg::VALUE_W-b62_pkg::CHUNK_W-1:0],
                            div_res.quotient};
          chunk_cnt     <= chunk_cnt + 1'b1;
          if (chunk_cnt == b62_pkg::LAST_CHUNK) begin
            rem <= '0;
            if (wr_pos == b62_pkg::FIRST_POS) begin
              digit_counter <= b62_pkg::FIRST_POS;
              state         <= ST_FETCH;
            end else begin
              wr_pos <= wr_pos - 1'b1;
            end
          end else begin
            rem <= div_res.remainder;
          end
        end
        ST_FETCH: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_load) begin
            out_valid <= 1'b1;
            out_char  <= b62_pkg::digit_char(store_rd_data);
            out_pos   <= digit_counter;
            out_last  <= (digit_counter == b62_pkg::LAST_POS);
            if (digit_counter == b62_pkg::LAST_POS) begin
              digit_counter <= b62_pkg::FIRST_POS;
              state         <= ST_IDLE;
            end else begin
              digit_counter <= digit_counter + 1'b1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign value_ch.ready        = (state == ST_IDLE);
  assign char_ch.valid         = out_valid;
  assign char_ch.char_code     = out_char;
  assign char_ch.digit_position = out_pos;
  assign char_ch.last_digit    = out_last;

endmodule

// ===== src/b62_checker.sv =====
// Port-level checker of the base-62 encoder, bound to the top level.
// Depends on b62_pkg and the assertion macros in base62_encode_128_macros.svh.
`include "base62_encode_128_macros.svh"

module b62_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [b62_pkg::CHAR_W-1:0]  char_code,
  input logic [b62_pkg::POS_W-1:0]   digit_position,
  input logic                        last_digit
);

  localparam logic [b62_pkg::POS_W:0] OWED_ITEM =
    (b62_pkg::POS_W + 1)'(b62_pkg::NUM_DIGITS);
  localparam logic [b62_pkg::POS_W:0] OWED_ONE = (b62_pkg::POS_W + 1)'(1);
  localparam logic [b62_pkg::CHAR_W-1:0] CODE_NINE    = 7'd57;
  localparam logic [b62_pkg::CHAR_W-1:0] CODE_UPPER_Z = 7'd90;
  localparam logic [b62_pkg::CHAR_W-1:0] CODE_LOWER_Z = 7'd122;

  logic [b62_pkg::POS_W-1:0] exp_pos;
  logic [b62_pkg::POS_W:0]   owed;
  logic                      in_xfer;
  logic                      out_xfer;
  logic                      at_last_pos;
  logic                      char_ok;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  assign at_last_pos = (digit_position == b62_pkg::LAST_POS);
  assign char_ok = ((char_code >= b62_pkg::ASCII_ZERO) && (char_code <= CODE_NINE)) ||
                   ((char_code >= b62_pkg::ASCII_UPPER_A) && (char_code <= CODE_UPPER_Z)) ||
                   ((char_code >= b62_pkg::ASCII_LOWER_A) && (char_code <= CODE_LOWER_Z));

  // Expected position of the next character and characters still owed.
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_pos <= b62_pkg::FIRST_POS;
      owed    <= '0;
    end else begin
      if (out_xfer) begin
        exp_pos <= (exp_pos == b62_pkg::LAST_POS) ? b62_pkg::FIRST_POS :
                   exp_pos + 1'b1;
      end
      if (in_xfer) begin
        // The last character of the previous value may still be waiting or leave now.
        owed <= out_xfer ? owed + OWED_ITEM - OWED_ONE : owed + OWED_ITEM;
      end else if (out_xfer && owed != '0) begin
        owed <= owed - OWED_ONE;
      end
    end
  end

  `B62_ASSERT_IMP(a_pos_in_order, clk, rst, out_valid, digit_position == exp_pos)
  `B62_ASSERT_IMP(a_last_at_end, clk, rst, out_valid, last_digit == at_last_pos)
  `B62_ASSERT_IMP(a_char_in_alphabet, clk, rst, out_valid, char_ok)
  `B62_ASSERT_IMP(a_no_extra_char, clk, rst, out_valid, owed != '0)
  `B62_ASSERT_IMP(a_ready_when_done, clk, rst, in_ready, owed <= OWED_ONE)

endmodule

bind base62_encode_128 b62_checker u_b62_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (value_ch.valid),
  .in_ready       (value_ch.ready),
  .out_valid      (char_ch.valid),
  .out_ready      (char_ch.ready),
  .char_code      (char_ch.char_code),
  .digit_position (char_ch.digit_position),
  .last_digit     (char_ch.last_digit)
);
